// ===== sv/lru_page_frame_manager_defines.svh =====
// Assertion macros for the page frame manager checker.
// Included by the checker file only; no other dependencies.
`ifndef LRU_PAGE_FRAME_MANAGER_DEFINES_SVH
`define LRU_PAGE_FRAME_MANAGER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LPFM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("page frame manager check failed");

// next-cycle implication, disabled while reset is asserted
`define LPFM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("page frame manager check failed");

`endif

// ===== sv/lpfm_pkg.sv =====
// Shared types and codes for the page frame manager.
// No dependencies; imported by every module of the block.
package lpfm_pkg;

	localparam int RANK_W = 6;

	localparam logic [2:0] CMD_GET     = 3'd0;
	localparam logic [2:0] CMD_GET_PIN = 3'd1;
	localparam logic [2:0] CMD_NEW     = 3'd2;
	localparam logic [2:0] CMD_NEW_PIN = 3'd3;
	localparam logic [2:0] CMD_UNPIN   = 3'd4;
	localparam logic [2:0] CMD_DIRTY   = 3'd5;

	localparam logic [1:0] STATUS_OK           = 2'd0;
	localparam logic [1:0] STATUS_NO_VICTIM    = 2'd1;
	localparam logic [1:0] STATUS_NOT_RESIDENT = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_PICK,
		S_UPD
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  table_id;
		logic [31:0] page_id;
	} req_t;

	typedef struct packed {
		logic [3:0]  frame;
		logic        hit;
		logic        load_needed;
		logic        writeback;
		logic [7:0]  victim_table;
		logic [31:0] victim_page;
		logic [1:0]  status;
		logic [31:0] assigned_page;
	} rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic              en;
		logic              touch;
		logic [RANK_W-1:0] ref_rank;
		logic              set_rank;
		logic [RANK_W-1:0] new_rank;
		logic              place;
		logic              wr_pin;
		logic              pin_val;
		logic              set_dirty;
		logic [7:0]        table_id;
		logic [31:0]       page_id;
	} cell_ctl_t;

	typedef struct packed {
		logic              valid;
		logic              pinned;
		logic              dirty;
		logic [7:0]        table_id;
		logic [31:0]       page_id;
		logic [RANK_W-1:0] rank;
	} cell_stat_t;

endpackage

// ===== sv/lru_page_frame_manager.sv =====
// Channel   Direction  Handshake            Payload
// in        to block   in_valid / in_stall   lpfm_pkg::req_t (command, table_id, page_id)
// out       from block out_valid / out_stall lpfm_pkg::rsp_t (frame ... assigned_page)
// cfg       to block   cfg_wr_en             cfg_wr_data = frames_in_use
//
// One request at a time: accept, lookup across the cell row, victim pick,
// update. The request is registered on accept, then steps through the lookup,
// pick and update states over the frame cells; the result beat is registered
// as the update step ends, and no new request is taken until the block is idle.
// The update step waits while an earlier result beat is stalled.
// Reset empties every frame, clears the anonymous counter and sets the
// frame limit to 16; no clearing pass is needed.
module lru_page_frame_manager #(
	parameter int NUM_FRAMES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  lpfm_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output lpfm_pkg::rsp_t out_data,
	input  logic           cfg_wr_en,
	input  logic [4:0]     cfg_wr_data
);
	import lpfm_pkg::*;

	localparam int RW = $clog2(NUM_FRAMES);

	logic [4:0]            frames_in_use_q;
	cell_ctl_t             ctl;
	logic [NUM_FRAMES-1:0] sel;
	logic [NUM_FRAMES-1:0] first_hit;
	logic [NUM_FRAMES:0]   found;
	cell_stat_t            stat [NUM_FRAMES];
	logic [7:0]            look_table;
	logic [31:0]           look_page;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= 5'd16;
		end else if (cfg_wr_en) begin
			frames_in_use_q <= cfg_wr_data;
		end
	end

	assign found[0] = 1'b0;

	for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
		lpfm_cell #(
			.RW(RW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sel        (sel[g]),
			.look_table (look_table),
			.look_page  (look_page),
			.found_in   (found[g]),
			.found_out  (found[g+1]),
			.first_hit  (first_hit[g]),
			.stat       (stat[g])
		);
	end

	lpfm_ctrl #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.frames_in_use (frames_in_use_q),
		.stat          (stat),
		.first_hit     (first_hit),
		.look_table    (look_table),
		.look_page     (look_page),
		.ctl           (ctl),
		.sel           (sel)
	);

endmodule

// ===== sv/lpfm_cell.sv =====
// One frame cell: key, pin, dirty and recency rank of a single buffer frame.
// Depends on lpfm_pkg; cells are chained through the first-match line.
module lpfm_cell #(
	parameter int RW = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lpfm_pkg::cell_ctl_t    ctl,
	input  logic                   sel,
	input  logic [7:0]             look_table,
	input  logic [31:0]            look_page,
	input  logic                   found_in,
	output logic                   found_out,
	output logic                   first_hit,
	output lpfm_pkg::cell_stat_t   stat
);
	import lpfm_pkg::*;

	logic               valid_q;
	logic               pinned_q;
	logic               dirty_q;
	logic [RW-1:0]      rank_q;
	logic [7:0]         table_q;
	logic [31:0]        page_q;
	logic               match;
	logic [RW+RANK_W-1:0] rank_ext;

	assign match     = valid_q && (table_q == look_table) && (page_q == look_page);
	// lowest-index match wins: pass the claim down the row
	assign first_hit = match && !found_in;
	assign found_out = found_in || match;

	assign rank_ext = {{RANK_W{1'b0}}, rank_q};

	always_comb begin
		stat.valid    = valid_q;
		stat.pinned   = pinned_q;
		stat.dirty    = dirty_q;
		stat.table_id = table_q;
		stat.page_id  = page_q;
		stat.rank     = rank_ext[RANK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			pinned_q <= 1'b0;
			dirty_q  <= 1'b0;
			rank_q   <= '0;
		end else if (ctl.en) begin
			if (sel) begin
				if (ctl.place) begin
					valid_q <= 1'b1;
					dirty_q <= 1'b0;
				end
				if (ctl.wr_pin) begin
					pinned_q <= ctl.pin_val;
				end
				if (ctl.set_dirty) begin
					dirty_q <= 1'b1;
				end
				if (ctl.set_rank) begin
					rank_q <= ctl.new_rank[RW-1:0];
				end
			end else if (ctl.touch && valid_q && (rank_q > ctl.ref_rank[RW-1:0])) begin
				// close the gap left by the frame that moves to the top
				rank_q <= rank_q - RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && sel && ctl.place) begin
			table_q <= ctl.table_id;
			page_q  <= ctl.page_id;
		end
	end

endmodule

// ===== sv/lpfm_ctrl.sv =====
// Request sequencer: lookup, victim pick, cell update and result register.
// Depends on lpfm_pkg; drives the broadcast into the row of lpfm_cell.
module lpfm_ctrl #(
	parameter int NUM_FRAMES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lpfm_pkg::req_t       in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lpfm_pkg::rsp_t       out_data,
	input  logic [4:0]           frames_in_use,
	input  lpfm_pkg::cell_stat_t stat [NUM_FRAMES],
	input  logic [NUM_FRAMES-1:0] first_hit,
	output logic [7:0]           look_table,
	output logic [31:0]          look_page,
	output lpfm_pkg::cell_ctl_t  ctl,
	output logic [NUM_FRAMES-1:0] sel
);
	import lpfm_pkg::*;

	localparam int IW = $clog2(NUM_FRAMES);
	localparam int FW = $clog2(NUM_FRAMES + 1);
	localparam int LW = (FW > 5) ? FW : 5;

	state_t                state_q, state_d;
	req_t                  req_q;
	logic [31:0]           anon_q;
	logic [FW-1:0]         filled_q;
	logic                  out_valid_q;
	rsp_t                  out_q;

	logic [NUM_FRAMES-1:0] hit_oh_q;
	logic                  hit_any_q;
	logic [RANK_W-1:0]     hit_rank_q;
	logic [NUM_FRAMES-1:0] byrank_q;
	logic [IW-1:0]         vr_q;
	logic                  vfound_q;

	logic [RANK_W-1:0]     hit_rank;
	logic [NUM_FRAMES-1:0] byrank;
	logic [IW-1:0]         vr;
	logic                  vfound;

	logic                  go;
	logic                  accept;
	logic [NUM_FRAMES-1:0] vic_oh;
	logic [NUM_FRAMES-1:0] fill_oh;
	logic [IW-1:0]         hit_idx;
	logic [IW-1:0]         vic_idx;
	logic                  vic_dirty;
	logic [7:0]            vic_table;
	logic [31:0]           vic_page;
	logic [4:0]            lim;
	logic                  fill_ok;
	logic [FW-1:0]         top_fw;
	logic [FW+RANK_W-1:0]  top_ext;
	logic [FW+RANK_W-1:0]  fill_ext;
	logic [IW+RANK_W-1:0]  vr_ext;
	logic [IW+3:0]         frame_ext;
	logic [IW-1:0]         tgt_idx;
	logic                  place_req;
	logic                  place_load;
	logic                  place_pin;
	logic [7:0]            place_table;
	logic [31:0]           place_page;
	logic                  placed;
	logic                  filling;
	rsp_t                  rsp;

	assign look_table = req_q.table_id;
	assign look_page  = req_q.page_id;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		accept   = 1'b0;
		go       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					accept  = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: state_d = S_PICK;
			S_PICK: state_d = S_UPD;
			S_UPD: begin
				// hold until the previous result beat has left
				if (!out_valid_q || !out_stall) begin
					go      = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// lookup summary: rank of the matched frame, unpinned ranks present
	always_comb begin
		hit_rank = '0;
		byrank   = '0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (first_hit[i]) begin
				hit_rank = hit_rank | stat[i].rank;
			end
			if (stat[i].valid && !stat[i].pinned) begin
				byrank[stat[i].rank[IW-1:0]] = 1'b1;
			end
		end
	end

	// lowest unpinned rank is the victim
	always_comb begin
		vr     = '0;
		vfound = 1'b0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (byrank_q[i]) begin
				vr     = IW'(i);
				vfound = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
		if (state_q == S_LOOK) begin
			hit_oh_q   <= first_hit;
			hit_any_q  <= |first_hit;
			hit_rank_q <= hit_rank;
			byrank_q   <= byrank;
		end
		if (state_q == S_PICK) begin
			vr_q     <= vr;
			vfound_q <= vfound;
		end
	end

	// frame selection and victim readout
	always_comb begin
		vic_oh    = '0;
		fill_oh   = '0;
		hit_idx   = '0;
		vic_idx   = '0;
		vic_dirty = 1'b0;
		vic_table = '0;
		vic_page  = '0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			vic_oh[i]  = stat[i].valid && (stat[i].rank[IW-1:0] == vr_q);
			fill_oh[i] = (filled_q == FW'(i));
			if (hit_oh_q[i]) begin
				hit_idx = hit_idx | IW'(i);
			end
			if (vic_oh[i]) begin
				vic_idx   = vic_idx | IW'(i);
				vic_dirty = vic_dirty | stat[i].dirty;
				vic_table = vic_table | stat[i].table_id;
				vic_page  = vic_page | stat[i].page_id;
			end
		end
	end

	assign lim      = (frames_in_use == 5'd0) ? 5'd1 : frames_in_use;
	assign fill_ok  = (filled_q < FW'(NUM_FRAMES)) && (LW'(filled_q) < LW'(lim));
	assign top_fw   = filled_q - FW'(1);
	assign top_ext  = {{RANK_W{1'b0}}, top_fw};
	assign fill_ext = {{RANK_W{1'b0}}, filled_q};
	assign vr_ext   = {{RANK_W{1'b0}}, vr_q};

	// result and cell broadcast
	always_comb begin
		rsp         = '0;
		ctl         = '0;
		sel         = '0;
		tgt_idx     = '0;
		place_req   = 1'b0;
		place_load  = 1'b0;
		place_pin   = 1'b0;
		place_table = '0;
		place_page  = '0;
		placed      = 1'b0;
		filling     = 1'b0;

		case (req_q.command)
			CMD_GET, CMD_GET_PIN: begin
				rsp.assigned_page = req_q.page_id;
				if (hit_any_q) begin
					sel          = hit_oh_q;
					ctl.touch    = 1'b1;
					ctl.ref_rank = hit_rank_q;
					ctl.set_rank = 1'b1;
					ctl.new_rank = top_ext[RANK_W-1:0];
					ctl.wr_pin   = (req_q.command == CMD_GET_PIN);
					ctl.pin_val  = 1'b1;
					tgt_idx      = hit_idx;
					rsp.hit      = 1'b1;
				end else begin
					place_req   = 1'b1;
					place_load  = 1'b1;
					place_pin   = (req_q.command == CMD_GET_PIN);
					place_table = req_q.table_id;
					place_page  = req_q.page_id;
				end
			end
			CMD_NEW, CMD_NEW_PIN: begin
				rsp.assigned_page = anon_q;
				place_req   = 1'b1;
				place_pin   = (req_q.command == CMD_NEW_PIN);
				place_table = 8'd0;
				place_page  = anon_q;
			end
			CMD_UNPIN, CMD_DIRTY: begin
				rsp.assigned_page = req_q.page_id;
				if (hit_any_q) begin
					sel           = hit_oh_q;
					ctl.wr_pin    = (req_q.command == CMD_UNPIN);
					ctl.pin_val   = 1'b0;
					ctl.set_dirty = (req_q.command == CMD_DIRTY);
					tgt_idx       = hit_idx;
					rsp.hit       = 1'b1;
				end else begin
					rsp.status = STATUS_NOT_RESIDENT;
				end
			end
			default: ;
		endcase

		if (place_req) begin
			ctl.table_id = place_table;
			ctl.page_id  = place_page;
			ctl.wr_pin   = 1'b1;
			ctl.pin_val  = place_pin;
			if (fill_ok) begin
				sel          = fill_oh;
				ctl.place    = 1'b1;
				ctl.set_rank = 1'b1;
				ctl.new_rank = fill_ext[RANK_W-1:0];
				tgt_idx      = filled_q[IW-1:0];
				placed       = 1'b1;
				filling      = 1'b1;
			end else if (vfound_q) begin
				sel              = vic_oh;
				ctl.place        = 1'b1;
				ctl.touch        = 1'b1;
				ctl.ref_rank     = vr_ext[RANK_W-1:0];
				ctl.set_rank     = 1'b1;
				ctl.new_rank     = top_ext[RANK_W-1:0];
				tgt_idx          = vic_idx;
				placed           = 1'b1;
				rsp.writeback    = vic_dirty;
				rsp.victim_table = vic_dirty ? vic_table : 8'd0;
				rsp.victim_page  = vic_dirty ? vic_page : 32'd0;
			end else begin
				ctl.wr_pin = 1'b0;
				rsp.status = STATUS_NO_VICTIM;
			end
			rsp.load_needed = placed && place_load;
		end

		frame_ext = {4'b0000, tgt_idx};
		rsp.frame = frame_ext[3:0];
		ctl.en    = go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			filled_q    <= '0;
			anon_q      <= '0;
		end else begin
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (go && filling) begin
				filled_q <= filled_q + FW'(1);
			end
			if (go && placed &&
			    ((req_q.command == CMD_NEW) || (req_q.command == CMD_NEW_PIN))) begin
				anon_q <= anon_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q <= rsp;
		end
	end

endmodule

// ===== sv/lpfm_checker.sv =====
// Port-level checks for the page frame manager, bound to the top level.
// Depends on lpfm_pkg and lru_page_frame_manager_defines.svh.
`include "lru_page_frame_manager_defines.svh"

module lpfm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input lpfm_pkg::rsp_t out_data
);
	import lpfm_pkg::*;

	logic err_beat;
	logic wb_beat;
	logic any_action;

	assign err_beat   = out_valid && (out_data.status != STATUS_OK);
	assign wb_beat    = out_valid && out_data.writeback;
	assign any_action = out_data.hit || out_data.load_needed || out_data.writeback;

	// one request in flight: the beat after an accepted one is refused
	`LPFM_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)

	`LPFM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// a failed request reports no frame action
	`LPFM_ASSERT_IMP(a_err_quiet, clk, arst_n, err_beat, !any_action)

	`LPFM_ASSERT_IMP(a_wb_on_evict, clk, arst_n, wb_beat, !out_data.hit && (out_data.status == STATUS_OK))

	`LPFM_ASSERT_IMP(a_hit_no_load, clk, arst_n, out_valid && out_data.hit, !out_data.load_needed)

endmodule

bind lru_page_frame_manager lpfm_checker u_lpfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== tb/lru_page_frame_manager_tb.sv =====
// Self-checking bench for the LRU page frame manager: random and directed requests
// against an in-bench frame table predictor, with valid/stall on both channels.
// Depends on lpfm_pkg and the lru_page_frame_manager top level.
`timescale 1ns / 1ps

module lru_page_frame_manager_tb;
	import lpfm_pkg::*;

	localparam int NUM_FRAMES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_LIMIT = 10;
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [4:0] cfg_wr_data = '0;

	// frame table as the block should hold it
	logic fr_valid [NUM_FRAMES];
	logic [7:0] fr_table [NUM_FRAMES];
	logic [31:0] fr_page [NUM_FRAMES];
	logic fr_pin [NUM_FRAMES];
	logic fr_dirty [NUM_FRAMES];
	int fr_rank [NUM_FRAMES];
	int fill_count = 0;
	logic [31:0] anon_next = '0;
	logic [4:0] limit_reg = 5'd16;

	req_t request_backlog [$];
	rsp_t frame_results_due [$];
	rsp_t want_rsp;

	logic no_idle = 1'b0;
	logic hold_long = 1'b0;
	int accepted_cnt = 0;
	int beats_seen = 0;
	int bad_beats = 0;
	int cycle_cnt = 0;
	int settings_cnt = 0;
	int hit_cnt = 0;
	int load_cnt = 0;
	int wb_cnt = 0;
	int refused_cnt = 0;
	int absent_cnt = 0;

	lru_page_frame_manager #(.NUM_FRAMES(NUM_FRAMES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	function automatic int frame_cap();
		int lim;
		lim = limit_reg;
		if (lim == 0) lim = 1;
		if (lim > NUM_FRAMES) lim = NUM_FRAMES;
		return lim;
	endfunction

	function automatic int lookup_frame(input logic [7:0] tbl, input logic [31:0] pg);
		for (int i = 0; i < NUM_FRAMES; i++)
			if (fr_valid[i] && fr_table[i] == tbl && fr_page[i] == pg)
				return i;
		return -1;
	endfunction

	function automatic void promote_frame(input int f);
		int r;
		r = fr_rank[f];
		for (int i = 0; i < NUM_FRAMES; i++)
			if (fr_valid[i] && fr_rank[i] > r)
				fr_rank[i]--;
		fr_rank[f] = fill_count - 1;
	endfunction

	// fill a free frame while under the limit, else evict the least recent unpinned one
	function automatic rsp_t place_page(input logic [7:0] tbl, input logic [31:0] pg,
			input logic pin, input logic load, input rsp_t r);
		int f;
		f = -1;
		if (fill_count < frame_cap()) begin
			f = fill_count;
			fr_valid[f] = 1'b1;
			fr_rank[f] = fill_count;
			fill_count++;
		end else begin
			for (int i = 0; i < NUM_FRAMES; i++)
				if (fr_valid[i] && !fr_pin[i] && (f < 0 || fr_rank[i] < fr_rank[f]))
					f = i;
			if (f < 0) begin
				r.status = STATUS_NO_VICTIM;
				return r;
			end
			if (fr_dirty[f]) begin
				r.writeback = 1'b1;
				r.victim_table = fr_table[f];
				r.victim_page = fr_page[f];
			end
			promote_frame(f);
		end
		fr_table[f] = tbl;
		fr_page[f] = pg;
		fr_pin[f] = pin;
		fr_dirty[f] = 1'b0;
		r.frame = f[3:0];
		r.load_needed = load;
		return r;
	endfunction

	function automatic rsp_t frame_decide(input req_t req);
		rsp_t r;
		int f;
		r = '0;
		case (req.command)
			CMD_GET, CMD_GET_PIN: begin
				r.assigned_page = req.page_id;
				f = lookup_frame(req.table_id, req.page_id);
				if (f >= 0) begin
					promote_frame(f);
					if (req.command == CMD_GET_PIN) fr_pin[f] = 1'b1;
					r.frame = f[3:0];
					r.hit = 1'b1;
				end else begin
					r = place_page(req.table_id, req.page_id, req.command == CMD_GET_PIN,
						1'b1, r);
				end
			end
			CMD_NEW, CMD_NEW_PIN: begin
				r.assigned_page = anon_next;
				r = place_page(8'd0, anon_next, req.command == CMD_NEW_PIN, 1'b0, r);
				// a refused placement leaves the counter alone
				if (r.status != STATUS_NO_VICTIM) anon_next = anon_next + 32'd1;
			end
			CMD_UNPIN, CMD_DIRTY: begin
				r.assigned_page = req.page_id;
				f = lookup_frame(req.table_id, req.page_id);
				if (f < 0) begin
					r.status = STATUS_NOT_RESIDENT;
				end else begin
					if (req.command == CMD_UNPIN) fr_pin[f] = 1'b0;
					else fr_dirty[f] = 1'b1;
					r.frame = f[3:0];
					r.hit = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// driver: hold a stalled beat, otherwise offer the next request or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				frame_results_due.insert(frame_results_due.size(), frame_decide(in_data));
				accepted_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (request_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
					in_valid <= 1'b1;
					in_data <= request_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check every result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				beats_seen++;
				if (frame_results_due.size() == 0) begin
					bad_beats++;
					if (bad_beats <= SHOW_LIMIT)
						$display("result beat %0d arrived with nothing due: %h", beats_seen,
							out_data);
				end else begin
					want_rsp = frame_results_due.pop_front();
					if (want_rsp.hit) hit_cnt++;
					if (want_rsp.load_needed) load_cnt++;
					if (want_rsp.writeback) wb_cnt++;
					if (want_rsp.status == STATUS_NO_VICTIM) refused_cnt++;
					if (want_rsp.status == STATUS_NOT_RESIDENT) absent_cnt++;
					if (out_data.frame !== want_rsp.frame || out_data.hit !== want_rsp.hit ||
							out_data.load_needed !== want_rsp.load_needed ||
							out_data.writeback !== want_rsp.writeback ||
							out_data.victim_table !== want_rsp.victim_table ||
							out_data.victim_page !== want_rsp.victim_page ||
							out_data.status !== want_rsp.status ||
							out_data.assigned_page !== want_rsp.assigned_page) begin
						bad_beats++;
						if (bad_beats <= SHOW_LIMIT) begin
							$display({"beat %0d expected: frame %0d hit %b load %b wb %b",
								" victim %h:%h status %0d page %h"},
								beats_seen, want_rsp.frame, want_rsp.hit, want_rsp.load_needed,
								want_rsp.writeback, want_rsp.victim_table, want_rsp.victim_page,
								want_rsp.status, want_rsp.assigned_page);
							$display({"beat %0d actual:   frame %0d hit %b load %b wb %b",
								" victim %h:%h status %0d page %h"},
								beats_seen, out_data.frame, out_data.hit, out_data.load_needed,
								out_data.writeback, out_data.victim_table, out_data.victim_page,
								out_data.status, out_data.assigned_page);
						end
					end
				end
			end
			out_stall <= hold_long || (!no_idle && $urandom_range(0, 99) < 25);
		end
	end

	// long receiver hold-off while requests keep coming, so the input backs up
	initial begin
		wait (accepted_cnt >= 600);
		@(posedge clk);
		hold_long <= 1'b1;
		repeat (300) @(posedge clk);
		hold_long <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_cnt,
				frame_results_due.size());
			$display("lru_page_frame_manager_tb: FAIL");
			$finish;
		end
	end

	task automatic push_req(input logic [2:0] cmd, input logic [7:0] tbl,
			input logic [31:0] pg);
		req_t req;
		req.command = cmd;
		req.table_id = tbl;
		req.page_id = pg;
		request_backlog.insert(request_backlog.size(), req);
	endtask

	task automatic wait_idle();
		while (request_backlog.size() != 0 || frame_results_due.size() != 0 || in_valid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limit(input logic [4:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_reg = value;
		settings_cnt++;
		@(negedge clk);
	endtask

	// mostly traffic on a small key set sized to the limit, plus some noise
	task automatic queue_random(input int n_items);
		int pool_n;
		int pick;
		int roll;
		logic [7:0] pool_tbl [24];
		logic [31:0] pool_pg [24];
		logic [2:0] cmd;
		logic [7:0] tbl;
		logic [31:0] pg;
		pool_n = frame_cap() + 4;
		for (int k = 0; k < pool_n; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				pool_tbl[k] = 8'd0;
				pool_pg[k] = $urandom_range(0, 400);
			end else begin
				pool_tbl[k] = $urandom;
				pool_pg[k] = $urandom;
			end
		end
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, pool_n - 1);
			roll = $urandom_range(0, 99);
			tbl = pool_tbl[pick];
			pg = pool_pg[pick];
			if (roll < 36) cmd = CMD_GET;
			else if (roll < 48) cmd = CMD_GET_PIN;
			else if (roll < 78) cmd = roll < 60 ? CMD_UNPIN : CMD_DIRTY;
			else if (roll < 92) cmd = roll < 86 ? CMD_NEW : CMD_NEW_PIN;
			else if (roll < 95) cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
			else cmd = $urandom_range(0, 1) ? CMD_GET : CMD_DIRTY;
			// fields that the command ignores, and the noise beats, get random keys
			if (roll >= 78) begin
				tbl = $urandom;
				pg = $urandom;
			end
			push_req(cmd, tbl, pg);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_FRAMES; i++) begin
			fr_valid[i] = 1'b0;
			fr_table[i] = '0;
			fr_page[i] = '0;
			fr_pin[i] = 1'b0;
			fr_dirty[i] = 1'b0;
			fr_rank[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// two frames: pin both, get refused, then unpin, dirty and evict
		set_limit(5'd2);
		push_req(CMD_GET_PIN, 8'hff, 32'hffffffff);
		push_req(CMD_NEW_PIN, 8'h00, 32'h0);
		push_req(CMD_GET, 8'h01, 32'h0);
		push_req(CMD_NEW, 8'hff, 32'hffffffff);
		push_req(CMD_GET, 8'h00, 32'h0);
		push_req(CMD_UNPIN, 8'hff, 32'hffffffff);
		push_req(CMD_DIRTY, 8'hff, 32'hffffffff);
		push_req(CMD_GET, 8'h5a, 32'ha5a5a5a5);
		push_req(CMD_UNPIN, 8'h12, 32'h34);
		push_req(CMD_DIRTY, 8'h80, 32'h80000000);
		push_req(CMD_SPARE6, 8'hff, 32'hffffffff);
		push_req(CMD_SPARE7, 8'h00, 32'h0);
		push_req(CMD_GET, 8'h5a, 32'ha5a5a5a5);
		push_req(CMD_GET, 8'h00, 32'h1);
		push_req(CMD_UNPIN, 8'h00, 32'h0);
		// anonymous page 1 lands beside the resident (0, 1): duplicate key
		push_req(CMD_NEW, 8'h00, 32'h0);
		push_req(CMD_GET, 8'h00, 32'h1);
		push_req(CMD_GET_PIN, 8'h00, 32'h1);
		push_req(CMD_GET, 8'h00, 32'h1);
		push_req(CMD_DIRTY, 8'h00, 32'h1);
		push_req(CMD_GET, 8'h33, 32'hcccccccc);
		push_req(CMD_NEW_PIN, 8'h55, 32'h55555555);
		wait_idle();

		// limit 0 acts as 1 and sits below the filled count; 31 clamps to all frames
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: set_limit(5'd0);
				1: set_limit(5'd3);
				2: set_limit(5'd1);
				3: set_limit(5'd5);
				4: set_limit(5'd8);
				5: set_limit(5'd31);
				6: set_limit(5'd16);
				7: set_limit(5'd4);
				default: set_limit(5'd20);
			endcase
			no_idle = (p == 4);
			queue_random(160);
			wait_idle();
		end
		no_idle = 1'b0;

		repeat (20) @(posedge clk);
		$display("%0d requests over %0d frame-limit settings: %0d hits, %0d loads, %0d write-backs",
			accepted_cnt, settings_cnt, hit_cnt, load_cnt, wb_cnt);
		$display("%0d refused for lack of an unpinned frame, %0d not resident, %0d bad beats",
			refused_cnt, absent_cnt, bad_beats);
		if (bad_beats == 0 && frame_results_due.size() == 0) begin
			$display("lru_page_frame_manager_tb: PASS");
		end else begin
			$display("lru_page_frame_manager_tb: FAIL");
		end
		$finish;
	end

endmodule
